// ----- src/hystart_pkg.sv -----
// ---------------------------------------------------------------------------
// hystart_pkg
// Shared types, widths, codes and reset values for the HyStart slow-start
// exit detector.
// ---------------------------------------------------------------------------
package hystart_pkg;

   // default width of time values (microseconds)
   localparam int TIME_BITS_DEF = 32;

   // fixed field widths
   localparam int MODE_W     = 2;
   localparam int WORD_W     = 32;
   localparam int SEG_W      = 16;
   localparam int LOW_WIN_W  = 10;
   localparam int DET_W      = 2;
   localparam int SAMPLES_W  = 8;
   localparam int WIN_PROD_W = LOW_WIN_W + SEG_W;

   // stream widths
   localparam int REQ_TUSER_W = MODE_W;
   localparam int REQ_TDATA_W = 208;
   localparam int RSP_TDATA_W = 40;

   // csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // event kinds
   typedef enum logic [MODE_W-1:0] {
      MODE_RTT  = 2'd0,
      MODE_WIN  = 2'd1,
      MODE_LOSS = 2'd2
   } mode_type;

   // detection selection
   typedef enum logic [DET_W-1:0] {
      DET_TRAIN = 2'd0,
      DET_DELAY = 2'd1,
      DET_BOTH  = 2'd2
   } det_type;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ENABLE        = 3'd0,
      REG_LOW_WINDOW    = 3'd1,
      REG_DETECT_MODE   = 3'd2,
      REG_MIN_SAMPLES   = 3'd3,
      REG_ACK_DELTA     = 3'd4,
      REG_DELAY_FLOOR   = 3'd5,
      REG_DELAY_CEILING = 3'd6
   } reg_type;

   // register reset values
   localparam logic                 ENABLE_RST        = 1'b1;
   localparam logic [LOW_WIN_W-1:0] LOW_WINDOW_RST    = 10'd8;
   localparam logic [DET_W-1:0]     DETECT_MODE_RST   = 2'd2;
   localparam logic [SAMPLES_W-1:0] MIN_SAMPLES_RST   = 8'd8;
   localparam logic [WORD_W-1:0]    ACK_DELTA_RST     = 32'd2000;
   localparam logic [WORD_W-1:0]    DELAY_FLOOR_RST   = 32'd2000;
   localparam logic [WORD_W-1:0]    DELAY_CEILING_RST = 32'd1000000;

endpackage

// ----- src/hystart_slow_start_exit_top.sv -----
// ---------------------------------------------------------------------------
// hystart_slow_start_exit_top
// Path: an accepted request waits in the input register; the state update
//   then loads the result register once it is empty or being read, so
//   response back-pressure holds the input register and req_tready.
// Throughput: one request per cycle while the response side is not stalled;
//   the state update between the input and result registers sets that rate.
// Reset: synchronous, active high; clears all detector state, the pipeline
//   valids, and loads the default register values.
// ---------------------------------------------------------------------------
module hystart_slow_start_exit_top #(
   parameter int TIME_BITS = hystart_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: now_us, rtt_us, cwnd_bytes, ssthresh_bytes, segment_bytes,
   //        acked_seq, high_tx_seq (lowest bits first)
   input  logic [hystart_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: mode
   input  logic [hystart_pkg::REQ_TUSER_W-1:0] req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: set_ssthresh, new_ssthresh, exit_found, round_started, zero pad
   output logic [hystart_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // register write port
   input  logic                                csr_we,
   input  logic [hystart_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [hystart_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int W  = hystart_pkg::WORD_W;
   localparam int TB = TIME_BITS;

   // ---------------- configuration registers ----------------
   logic                                 enable_ff;
   logic [hystart_pkg::LOW_WIN_W-1:0]    low_win_ff;
   logic [hystart_pkg::DET_W-1:0]        det_mode_ff;
   logic [hystart_pkg::SAMPLES_W-1:0]    min_samples_ff;
   logic [TB-1:0]                        ack_delta_ff;
   logic [TB-1:0]                        floor_ff;
   logic [TB-1:0]                        ceiling_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= hystart_pkg::ENABLE_RST;
         low_win_ff     <= hystart_pkg::LOW_WINDOW_RST;
         det_mode_ff    <= hystart_pkg::DETECT_MODE_RST;
         min_samples_ff <= hystart_pkg::MIN_SAMPLES_RST;
         ack_delta_ff   <= TB'(hystart_pkg::ACK_DELTA_RST);
         floor_ff       <= TB'(hystart_pkg::DELAY_FLOOR_RST);
         ceiling_ff     <= TB'(hystart_pkg::DELAY_CEILING_RST);
      end else if (csr_we) begin
         case (hystart_pkg::reg_type'(csr_addr))
            hystart_pkg::REG_ENABLE:        enable_ff      <= csr_wdata[0];
            hystart_pkg::REG_LOW_WINDOW:
               low_win_ff <= csr_wdata[hystart_pkg::LOW_WIN_W-1:0];
            hystart_pkg::REG_DETECT_MODE:
               det_mode_ff <= csr_wdata[hystart_pkg::DET_W-1:0];
            hystart_pkg::REG_MIN_SAMPLES:
               min_samples_ff <= csr_wdata[hystart_pkg::SAMPLES_W-1:0];
            hystart_pkg::REG_ACK_DELTA:     ack_delta_ff   <= TB'(csr_wdata);
            hystart_pkg::REG_DELAY_FLOOR:   floor_ff       <= TB'(csr_wdata);
            hystart_pkg::REG_DELAY_CEILING: ceiling_ff     <= TB'(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                              in_valid_ff, in_valid_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   hystart_pkg::mode_type             mode_ff;
   logic [TB-1:0]                     now_ff;
   logic [TB-1:0]                     rtt_ff;
   logic [W-1:0]                      cwnd_ff;
   logic [W-1:0]                      ssth_ff;
   logic [hystart_pkg::SEG_W-1:0]     seg_ff;
   logic [W-1:0]                      acked_ff;
   logic [W-1:0]                      high_tx_ff;
   logic                              req_take;
   logic                              advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff    <= hystart_pkg::mode_type'(req_tuser);
         now_ff     <= TB'(req_tdata[31:0]);
         rtt_ff     <= TB'(req_tdata[63:32]);
         cwnd_ff    <= req_tdata[95:64];
         ssth_ff    <= req_tdata[127:96];
         seg_ff     <= req_tdata[143:128];
         acked_ff   <= req_tdata[175:144];
         high_tx_ff <= req_tdata[207:176];
      end
   end

   // ---------------- detector state ----------------
   logic                              found_ff, found_in;
   logic                              round_valid_ff, round_valid_in;
   logic [TB-1:0]                     round_start_ff, round_start_in;
   logic [TB-1:0]                     last_train_ff, last_train_in;
   logic [W-1:0]                      round_end_ff, round_end_in;
   logic [TB-1:0]                     rmin_ff, rmin_in;
   logic                              rmin_valid_ff, rmin_valid_in;
   logic [hystart_pkg::SAMPLES_W-1:0] samples_ff, samples_in;
   logic [TB-1:0]                     omin_ff, omin_in;
   logic                              omin_valid_ff, omin_valid_in;

   // ---------------- event evaluation ----------------
   logic                               rtt_nz;
   logic [TB-1:0]                      omin_new;
   logic [hystart_pkg::WIN_PROD_W-1:0] win_floor;
   logic                               in_range;
   logic                               run;
   logic [TB-1:0]                      gap;
   logic [TB-1:0]                      elapsed;
   logic                               train_hit;
   logic                               train_ok, delay_ok;
   logic                               train_fire, delay_fire;
   logic                               sample_phase;
   logic [TB-1:0]                      thresh;
   logic [TB-1:0]                      excess;
   logic                               fired;
   logic                               started;
   logic [W-1:0]                       seq_diff;
   logic                               round_pass;

   assign rtt_nz   = (rtt_ff != '0);
   assign omin_new = (!omin_valid_ff || omin_ff > rtt_ff) ? rtt_ff : omin_ff;

   // cwnd window check: low window in segments times segment size
   assign win_floor = hystart_pkg::WIN_PROD_W'(low_win_ff)
                    * hystart_pkg::WIN_PROD_W'(seg_ff);
   assign in_range  = enable_ff && (cwnd_ff <= ssth_ff)
                    && (W'(win_floor) <= cwnd_ff);
   // detection runs on RTT samples only
   assign run       = (mode_ff == hystart_pkg::MODE_RTT) && rtt_nz && in_range
                    && !found_ff;

   assign train_ok = (det_mode_ff == hystart_pkg::DET_TRAIN)
                  || (det_mode_ff == hystart_pkg::DET_BOTH);
   assign delay_ok = (det_mode_ff == hystart_pkg::DET_DELAY)
                  || (det_mode_ff == hystart_pkg::DET_BOTH);

   // ACK train: closely spaced ACKs lasting longer than the min RTT
   assign gap        = now_ff - last_train_ff;
   assign elapsed    = now_ff - round_start_ff;
   assign train_hit  = round_valid_ff && (gap <= ack_delta_ff);
   assign train_fire = train_hit && (elapsed > omin_new) && train_ok;

   // delay increase over clamped threshold
   assign sample_phase = (samples_ff < min_samples_ff);
   always_comb begin
      if (omin_new > ceiling_ff)
         thresh = ceiling_ff;
      else if (omin_new < floor_ff)
         thresh = floor_ff;
      else
         thresh = omin_new;
   end
   assign excess     = rmin_ff - omin_new;
   assign delay_fire = !sample_phase && rmin_valid_ff && (rmin_ff > omin_new)
                    && (excess > thresh) && delay_ok;

   assign fired = run && (train_fire || delay_fire);

   // serial comparison of acked sequence against round end
   assign seq_diff   = acked_ff - round_end_ff;
   assign round_pass = (seq_diff != '0) && !seq_diff[W-1];

   // next state
   always_comb begin
      found_in       = found_ff;
      round_valid_in = round_valid_ff;
      round_start_in = round_start_ff;
      last_train_in  = last_train_ff;
      round_end_in   = round_end_ff;
      rmin_in        = rmin_ff;
      rmin_valid_in  = rmin_valid_ff;
      samples_in     = samples_ff;
      omin_in        = omin_ff;
      omin_valid_in  = omin_valid_ff;
      started        = 1'b0;

      case (mode_ff)
         hystart_pkg::MODE_RTT: begin
            if (rtt_nz) begin
               omin_in       = omin_new;
               omin_valid_in = 1'b1;
            end
            if (run) begin
               if (train_hit)
                  last_train_in = now_ff;
               if (sample_phase) begin
                  if (!rmin_valid_ff || rmin_ff > rtt_ff)
                     rmin_in = rtt_ff;
                  rmin_valid_in = 1'b1;
                  samples_in    = samples_ff + 1'b1;
               end
               found_in = found_ff | fired;
            end
         end
         hystart_pkg::MODE_WIN: begin
            if (enable_ff && (cwnd_ff < ssth_ff) && round_pass)
               started = 1'b1;
         end
         hystart_pkg::MODE_LOSS: begin
            omin_in       = '0;
            omin_valid_in = 1'b0;
            found_in      = 1'b0;
            started       = 1'b1;
         end
         default: ;
      endcase

      // start of a new measurement round
      if (started) begin
         round_valid_in = 1'b1;
         round_start_in = now_ff;
         last_train_in  = now_ff;
         round_end_in   = high_tx_ff;
         rmin_in        = '0;
         rmin_valid_in  = 1'b0;
         samples_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff       <= 1'b0;
         round_valid_ff <= 1'b0;
         round_start_ff <= '0;
         last_train_ff  <= '0;
         round_end_ff   <= '0;
         rmin_ff        <= '0;
         rmin_valid_ff  <= 1'b0;
         samples_ff     <= '0;
         omin_ff        <= '0;
         omin_valid_ff  <= 1'b0;
      end else if (advance) begin
         found_ff       <= found_in;
         round_valid_ff <= round_valid_in;
         round_start_ff <= round_start_in;
         last_train_ff  <= last_train_in;
         round_end_ff   <= round_end_in;
         rmin_ff        <= rmin_in;
         rmin_valid_ff  <= rmin_valid_in;
         samples_ff     <= samples_in;
         omin_ff        <= omin_in;
         omin_valid_ff  <= omin_valid_in;
      end
   end

   // ---------------- result register ----------------
   logic [hystart_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      rsp_data_in = {5'd0, started, found_in, (fired ? cwnd_ff : '0), fired};
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- src/hystart_checker.sv -----
// ---------------------------------------------------------------------------
// hystart_checker
// Port-level checks on the HyStart detector's response stream, bound to
// the top level.
// ---------------------------------------------------------------------------
module hystart_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [hystart_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // an exit always leaves the found flag set
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[33])
      else $error("exit reported without found flag");

   // no exit means no ssthresh value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == '0)
      else $error("ssthresh value without exit");

   // an exit comes from an RTT sample, a new round never does
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[34]))
      else $error("exit and round start on one event");

endmodule

bind hystart_slow_start_exit_top hystart_checker u_hystart_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/hystart_slow_start_exit_top_tb.sv -----
// ---------------------------------------------------------------------------
// hystart_slow_start_exit_top_tb
// Self-checking bench for the HyStart slow-start exit detector. A short
// table of directed requests and register writes covers the corner cases;
// random phases then emulate a connection (RTT samples, window checks,
// losses) under varied register settings, random request gaps and response
// stalls. Responses are checked against an in-bench predictor or typed rows.
// ---------------------------------------------------------------------------
module hystart_slow_start_exit_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_W    = hystart_pkg::WORD_W;
   localparam int MODE_W    = hystart_pkg::MODE_W;
   localparam int DET_W     = hystart_pkg::DET_W;
   localparam int SEG_W     = hystart_pkg::SEG_W;
   localparam int LOW_WIN_W = hystart_pkg::LOW_WIN_W;
   localparam int SAMPLES_W = hystart_pkg::SAMPLES_W;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_COUNT   = 16;
   localparam int PHASE_ITEMS   = 120;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [WORD_W-1:0] WORD_MAX    = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] SERIAL_HALF = 32'h8000_0000;
   // codes the package enums leave out
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [DET_W-1:0]  DET_NONE    = 2'd3;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [WORD_W-1:0] now_us;
      logic [WORD_W-1:0] rtt_us;
      logic [WORD_W-1:0] cwnd;
      logic [WORD_W-1:0] ssth;
      logic [SEG_W-1:0]  seg;
      logic [WORD_W-1:0] acked;
      logic [WORD_W-1:0] high_tx;
   } ack_event_type;

   typedef struct {
      logic              set_ssth;
      logic [WORD_W-1:0] new_ssth;
      logic              found;
      logic              started;
   } exit_result_type;

   typedef struct {
      bit                   csr_write;
      hystart_pkg::reg_type csr_idx;
      logic [31:0]          csr_val;
      ack_event_type        ev;
      bit                   typed;
      exit_result_type      want;
   } stim_row_type;

   // DUT ports; the inputs are all known from time zero
   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [hystart_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [hystart_pkg::REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [hystart_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                                csr_we     = 1'b0;
   logic [hystart_pkg::CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [hystart_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   // register shadow
   logic                 cfg_enable      = hystart_pkg::ENABLE_RST;
   logic [LOW_WIN_W-1:0] cfg_low_window  = hystart_pkg::LOW_WINDOW_RST;
   logic [DET_W-1:0]     cfg_detect      = hystart_pkg::DETECT_MODE_RST;
   logic [SAMPLES_W-1:0] cfg_min_samples = hystart_pkg::MIN_SAMPLES_RST;
   logic [WORD_W-1:0]    cfg_ack_delta   = hystart_pkg::ACK_DELTA_RST;
   logic [WORD_W-1:0]    cfg_floor       = hystart_pkg::DELAY_FLOOR_RST;
   logic [WORD_W-1:0]    cfg_ceiling     = hystart_pkg::DELAY_CEILING_RST;

   // predicted detector state
   logic                 found_flag     = 1'b0;
   logic                 round_live     = 1'b0;
   logic [WORD_W-1:0]    round_t0       = '0;
   logic [WORD_W-1:0]    train_t        = '0;
   logic [WORD_W-1:0]    round_end      = '0;
   logic [WORD_W-1:0]    round_min      = '0;
   logic                 round_min_ok   = 1'b0;
   logic [SAMPLES_W-1:0] sample_cnt     = '0;
   logic [WORD_W-1:0]    base_rtt       = '0;
   logic                 base_rtt_ok    = 1'b0;

   exit_result_type exit_results_q[$];
   stim_row_type    stim_table[$];
   int              mismatch_count  = 0;
   int              cycle_count     = 0;
   int              req_gap_max     = 12;
   int              rsp_stall_max   = 12;
   int              hold_off_cycles = 0;

   hystart_slow_start_exit_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // new measurement round
   function automatic void start_round(logic [WORD_W-1:0] now, logic [WORD_W-1:0] high);
      round_live   = 1'b1;
      round_t0     = now;
      train_t      = now;
      round_end    = high;
      round_min    = '0;
      round_min_ok = 1'b0;
      sample_cnt   = '0;
   endfunction

   // advances the detector state by one event and returns the response
   function automatic exit_result_type predict_exit_event(ack_event_type ev);
      exit_result_type   res;
      logic [WORD_W-1:0] win_floor;
      logic [WORD_W-1:0] gap_us;
      logic [WORD_W-1:0] thresh;
      logic [WORD_W-1:0] seq_delta;
      bit                train_on;
      bit                delay_on;
      bit                fired;
      bit                started;
      fired     = 1'b0;
      started   = 1'b0;
      train_on  = (cfg_detect == hystart_pkg::DET_TRAIN)
               || (cfg_detect == hystart_pkg::DET_BOTH);
      delay_on  = (cfg_detect == hystart_pkg::DET_DELAY)
               || (cfg_detect == hystart_pkg::DET_BOTH);
      win_floor = 32'(cfg_low_window) * 32'(ev.seg);
      case (ev.mode)
         hystart_pkg::MODE_RTT: begin
            if (ev.rtt_us != '0) begin
               if (!base_rtt_ok || base_rtt > ev.rtt_us) begin
                  base_rtt    = ev.rtt_us;
                  base_rtt_ok = 1'b1;
               end
               if (cfg_enable && ev.cwnd <= ev.ssth && ev.cwnd >= win_floor
                   && !found_flag) begin
                  // ACK train
                  gap_us = ev.now_us - train_t;
                  if (round_live && gap_us <= cfg_ack_delta) begin
                     train_t = ev.now_us;
                     gap_us  = ev.now_us - round_t0;
                     if (gap_us > base_rtt && train_on) found_flag = 1'b1;
                  end
                  // delay increase over the round's first samples
                  if (sample_cnt < cfg_min_samples) begin
                     if (!round_min_ok || round_min > ev.rtt_us) begin
                        round_min    = ev.rtt_us;
                        round_min_ok = 1'b1;
                     end
                     sample_cnt = sample_cnt + 1'b1;
                  end else if (round_min_ok) begin
                     if (base_rtt > cfg_ceiling)    thresh = cfg_ceiling;
                     else if (base_rtt < cfg_floor) thresh = cfg_floor;
                     else                           thresh = base_rtt;
                     if (round_min > base_rtt && (round_min - base_rtt) > thresh
                         && delay_on)
                        found_flag = 1'b1;
                  end
                  fired = found_flag;
               end
            end
         end
         hystart_pkg::MODE_WIN: begin
            if (cfg_enable && ev.cwnd < ev.ssth) begin
               seq_delta = ev.acked - round_end;
               if (seq_delta != '0 && seq_delta < SERIAL_HALF) begin
                  start_round(ev.now_us, ev.high_tx);
                  started = 1'b1;
               end
            end
         end
         hystart_pkg::MODE_LOSS: begin
            base_rtt    = '0;
            base_rtt_ok = 1'b0;
            found_flag  = 1'b0;
            start_round(ev.now_us, ev.high_tx);
            started = 1'b1;
         end
         default: ;
      endcase
      res.set_ssth = fired;
      res.new_ssth = fired ? ev.cwnd : '0;
      res.found    = found_flag;
      res.started  = started;
      return res;
   endfunction

   function automatic stim_row_type ev_row(logic [MODE_W-1:0] mode, logic [WORD_W-1:0] now,
                                           logic [WORD_W-1:0] rtt, logic [WORD_W-1:0] cwnd,
                                           logic [WORD_W-1:0] ssth, logic [SEG_W-1:0] seg,
                                           logic [WORD_W-1:0] acked, logic [WORD_W-1:0] high,
                                           bit typed = 1'b0, bit found = 1'b0,
                                           bit started = 1'b0);
      stim_row_type row;
      row.csr_write  = 1'b0;
      row.csr_idx    = hystart_pkg::REG_ENABLE;
      row.csr_val    = '0;
      row.ev         = '{mode, now, rtt, cwnd, ssth, seg, acked, high};
      row.typed      = typed;
      row.want       = '{1'b0, '0, found, started};
      return row;
   endfunction

   function automatic stim_row_type cfg_row(hystart_pkg::reg_type idx, logic [31:0] val);
      stim_row_type row;
      row           = ev_row(MODE_UNUSED, '0, '0, '0, '0, '0, '0, '0);
      row.csr_write = 1'b1;
      row.csr_idx   = idx;
      row.csr_val   = val;
      return row;
   endfunction

   // first two phases take the extremes, the rest a random mix
   function automatic logic [31:0] pick_extreme(int phase, logic [31:0] low,
                                                logic [31:0] high, logic [31:0] typical,
                                                logic [31:0] spread);
      int sel;
      sel = (phase < 2) ? phase : $urandom_range(0, 5);
      case (sel)
         0:       return low;
         1:       return high;
         2, 3:    return typical;
         default: return low + $urandom_range(0, spread);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // stop offering, let every expected response come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (exit_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(hystart_pkg::reg_type idx, logic [31:0] val);
      wait_for_drain();
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         hystart_pkg::REG_ENABLE:        cfg_enable      = val[0];
         hystart_pkg::REG_LOW_WINDOW:    cfg_low_window  = val[LOW_WIN_W-1:0];
         hystart_pkg::REG_DETECT_MODE:   cfg_detect      = val[DET_W-1:0];
         hystart_pkg::REG_MIN_SAMPLES:   cfg_min_samples = val[SAMPLES_W-1:0];
         hystart_pkg::REG_ACK_DELTA:     cfg_ack_delta   = val;
         hystart_pkg::REG_DELAY_FLOOR:   cfg_floor       = val;
         hystart_pkg::REG_DELAY_CEILING: cfg_ceiling     = val;
         default: ;
      endcase
   endtask

   // offer one request after a random gap; predict on acceptance
   task automatic send_request(ack_event_type ev, bit typed, exit_result_type want);
      int              gap;
      exit_result_type res;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ev.mode;
      req_tdata  <= {ev.high_tx, ev.acked, ev.seg, ev.ssth, ev.cwnd, ev.rtt_us, ev.now_us};
      do @(posedge clock); while (!req_tready);
      res = predict_exit_event(ev);
      exit_results_q.push_back(typed ? want : res);
   endtask

   // response side: random stalls plus an occasional long hold-off
   initial begin : rsp_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // response check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      exit_result_type got;
      exit_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.set_ssth = rsp_tdata[0];
         got.new_ssth = rsp_tdata[32:1];
         got.found    = rsp_tdata[33];
         got.started  = rsp_tdata[34];
         if (exit_results_q.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_tdata[31:0], '0);
         end else begin
            want = exit_results_q.pop_front();
            if (got.set_ssth !== want.set_ssth)
               report_mismatch("set_ssthresh", got.set_ssth, want.set_ssth);
            if (got.new_ssth !== want.new_ssth)
               report_mismatch("new_ssthresh", got.new_ssth, want.new_ssth);
            if (got.found !== want.found)
               report_mismatch("exit_found", got.found, want.found);
            if (got.started !== want.started)
               report_mismatch("round_started", got.started, want.started);
         end
      end
   end

   // stimulus
   initial begin : stim_main
      ack_event_type     ev;
      exit_result_type   none;
      int                roll;
      int                phase;
      int                item;
      logic [WORD_W-1:0] conn_now;
      logic [WORD_W-1:0] conn_rtt;
      logic [WORD_W-1:0] conn_spread;
      logic [WORD_W-1:0] conn_acked;
      logic [WORD_W-1:0] conn_high;
      logic [SEG_W-1:0]  conn_seg;

      none = '{1'b0, '0, 1'b0, 1'b0};

      // directed table, reset values first
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 0, 0, 10000, 20000, 1000, 0, 0,
                                  1, 0, 0));
      stim_table.push_back(ev_row(hystart_pkg::MODE_WIN, 100, 0, 0, 1, 1, 1, 50000,
                                  1, 0, 1));
      // cwnd equal to ssthresh and to the low window
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 200, 100, 8000, 8000, 1000, 0, 0));
      // train longer than the minimum RTT
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 400, 150, 8000, 9000, 1000, 0, 0));
      // already found
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 500, 90, 8000, 9000, 1000, 0, 0));
      stim_table.push_back(ev_row(hystart_pkg::MODE_LOSS, 1000, 0, 0, 0, 1, 0, 5000,
                                  1, 0, 1));
      stim_table.push_back(ev_row(MODE_UNUSED, 1100, 7, 1, 2, 1, 9000, 9000, 1, 0, 0));
      // serial compare: equal, half range ahead, cwnd not below ssthresh
      stim_table.push_back(ev_row(hystart_pkg::MODE_WIN, 1200, 0, 0, 1, 1, 5000, 6000,
                                  1, 0, 0));
      stim_table.push_back(ev_row(hystart_pkg::MODE_WIN, 1200, 0, 0, 1, 1,
                                  5000 + SERIAL_HALF, 6000, 1, 0, 0));
      stim_table.push_back(ev_row(hystart_pkg::MODE_WIN, 1200, 0, 1, 1, 1, 5001, 6000,
                                  1, 0, 0));
      // field extremes and time wrap
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, WORD_MAX, WORD_MAX, WORD_MAX,
                                  WORD_MAX, 16'hFFFF, WORD_MAX, WORD_MAX));
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 0, 1, 8, 8, 1, 0, 0));
      // delay test alone
      stim_table.push_back(cfg_row(hystart_pkg::REG_DETECT_MODE, hystart_pkg::DET_DELAY));
      stim_table.push_back(cfg_row(hystart_pkg::REG_MIN_SAMPLES, 2));
      stim_table.push_back(ev_row(hystart_pkg::MODE_LOSS, 0, 0, 0, 0, 1, 0, 0, 1, 0, 1));
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 10, 5000, 8000, WORD_MAX, 1000,
                                  0, 0));
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 20, 5000, 8000, WORD_MAX, 1000,
                                  0, 0));
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 30, 100, 8000, WORD_MAX, 1000,
                                  0, 0));
      // no round minimum with zero samples
      stim_table.push_back(cfg_row(hystart_pkg::REG_MIN_SAMPLES, 0));
      stim_table.push_back(ev_row(hystart_pkg::MODE_LOSS, 40, 0, 0, 0, 1, 0, 0, 1, 0, 1));
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 50, 5000, 8000, WORD_MAX, 1000,
                                  0, 0));
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 60, 100, 8000, WORD_MAX, 1000,
                                  0, 0));
      // unused detect mode: train advances, nothing fires
      stim_table.push_back(cfg_row(hystart_pkg::REG_DETECT_MODE, DET_NONE));
      stim_table.push_back(cfg_row(hystart_pkg::REG_MIN_SAMPLES, 8));
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 1500, 100, 8000, WORD_MAX, 1000,
                                  0, 0));
      // floor above ceiling: ceiling wins above it
      stim_table.push_back(cfg_row(hystart_pkg::REG_DELAY_FLOOR, 5000));
      stim_table.push_back(cfg_row(hystart_pkg::REG_DELAY_CEILING, 1000));
      stim_table.push_back(cfg_row(hystart_pkg::REG_DETECT_MODE, hystart_pkg::DET_DELAY));
      stim_table.push_back(cfg_row(hystart_pkg::REG_MIN_SAMPLES, 1));
      stim_table.push_back(ev_row(hystart_pkg::MODE_LOSS, 2000, 0, 0, 0, 1, 0, 0, 1, 0, 1));
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 2010, 3000, 8000, WORD_MAX, 1000,
                                  0, 0));
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 2020, 1500, 8000, WORD_MAX, 1000,
                                  0, 0));
      // detection off
      stim_table.push_back(cfg_row(hystart_pkg::REG_ENABLE, 0));
      stim_table.push_back(ev_row(hystart_pkg::MODE_RTT, 2030, 10, 8000, WORD_MAX, 1000,
                                  0, 0));
      stim_table.push_back(ev_row(hystart_pkg::MODE_WIN, 2040, 0, 0, 1, 1, 77777, 88888));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].csr_write)
            write_reg(stim_table[i].csr_idx, stim_table[i].csr_val);
         else
            send_request(stim_table[i].ev, stim_table[i].typed, stim_table[i].want);
      end

      // random phases: one emulated connection per register setting
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         write_reg(hystart_pkg::REG_ENABLE,        pick_extreme(phase, 0, 1, 1, 1));
         write_reg(hystart_pkg::REG_LOW_WINDOW,    pick_extreme(phase, 0, 1023, 8, 32));
         write_reg(hystart_pkg::REG_DETECT_MODE,
                   pick_extreme(phase, hystart_pkg::DET_TRAIN, hystart_pkg::DET_BOTH,
                                hystart_pkg::DET_BOTH, 3));
         write_reg(hystart_pkg::REG_MIN_SAMPLES,   pick_extreme(phase, 0, 255, 8, 16));
         write_reg(hystart_pkg::REG_ACK_DELTA,     pick_extreme(phase, 0, WORD_MAX, 2000, 5000));
         write_reg(hystart_pkg::REG_DELAY_FLOOR,   pick_extreme(phase, 0, WORD_MAX, 2000, 5000));
         write_reg(hystart_pkg::REG_DELAY_CEILING,
                   pick_extreme(phase, 0, WORD_MAX, 1000000, 2000000));

         req_gap_max   = (phase % 3 == 2) ? 0 : 12;
         rsp_stall_max = (phase % 4 == 1) ? 0 : 12;
         // long receiver hold-off while the sender keeps offering
         if (phase == 3) begin
            req_gap_max     = 0;
            hold_off_cycles = HOLD_CYCLES;
         end

         conn_now    = (phase % 4 == 0) ? 32'hFFFF_C000 : $urandom;
         conn_rtt    = $urandom_range(50, 20000);
         conn_spread = $urandom_range(0, 3) * conn_rtt;
         conn_acked  = $urandom;
         conn_high   = conn_acked + $urandom_range(1, 60000);
         conn_seg    = $urandom_range(1, 1500);

         for (item = 0; item < PHASE_ITEMS; item++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               // noise
               ev.mode    = $urandom_range(0, 3);
               ev.now_us  = $urandom;
               ev.rtt_us  = $urandom;
               ev.cwnd    = $urandom;
               ev.ssth    = $urandom;
               ev.seg     = $urandom_range(1, 65535);
               ev.acked   = $urandom;
               ev.high_tx = $urandom;
            end else begin
               conn_now  = conn_now + $urandom_range(0, 2500);
               ev.now_us = conn_now;
               ev.rtt_us = '0;
               if (roll < 10) begin
                  ev.mode  = hystart_pkg::MODE_LOSS;
                  conn_rtt = $urandom_range(50, 20000);
               end else if (roll < 30) begin
                  ev.mode = hystart_pkg::MODE_WIN;
                  if ($urandom_range(0, 15) == 0)
                     conn_acked = conn_acked - $urandom_range(1, 100000);
                  else
                     conn_acked = conn_acked + $urandom_range(0, 4000);
                  conn_high = conn_acked + $urandom_range(1, 60000);
                  // queueing delay builds up round by round
                  if ($urandom_range(0, 1) == 0) conn_rtt = conn_rtt + $urandom_range(0, 3000);
               end else begin
                  ev.mode = hystart_pkg::MODE_RTT;
                  if ($urandom_range(0, 31) != 0)
                     ev.rtt_us = conn_rtt + $urandom_range(0, conn_spread);
               end
               ev.seg     = conn_seg;
               ev.cwnd    = 32'(conn_seg) * $urandom_range(0, 40);
               case ($urandom_range(0, 9))
                  0:       ev.ssth = ev.cwnd;
                  1:       ev.ssth = ev.cwnd - 1;
                  default: ev.ssth = ev.cwnd + $urandom_range(1, 1 << 20);
               endcase
               ev.acked   = conn_acked;
               ev.high_tx = conn_high;
            end
            send_request(ev, 1'b0, none);
         end
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
